// File: hw/rtl/dol_default_value_filler_macros.svh
// Assertion helpers for the DOL filler.
`ifndef DOL_DEFAULT_VALUE_FILLER_MACROS_SVH
`define DOL_DEFAULT_VALUE_FILLER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DVF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define DVF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dvf_pkg.sv
package dvf_pkg;

  localparam int ENTRY_BYTES      = 20;
  localparam int BYTES_PER_RESULT = 8;
  localparam int MAX_RESULTS      = 32;
  localparam int ROM_ENTRIES      = 13;
  localparam int ROM_STORED       = 20;
  localparam logic [3:0] UNKNOWN_ENTRY = 4'd13;

  localparam logic [15:0] ROM_TAG [ROM_ENTRIES] = '{
    16'h9F59, 16'h9F5A, 16'h9F58, 16'h9F66, 16'h9F02, 16'h9F03, 16'h9F1A,
    16'h5F2A, 16'h0095, 16'h009A, 16'h009C, 16'h0098, 16'h9F37
  };

  // One result word in flight toward the output.
  typedef struct packed {
    logic [63:0] fill;
    logic [3:0]  count;
    logic        known;
    logic        last;
  } out_word_t;

  function automatic logic is_short_tag(input logic [7:0] b);
    return (b == 8'h95) || (b == 8'h9A) || (b == 8'h9C) || (b == 8'h98);
  endfunction

  // First matching entry, else unknown.
  function automatic logic [3:0] match_tag(input logic [15:0] tag);
    logic [3:0] hit;
    hit = UNKNOWN_ENTRY;
    for (int j = ROM_ENTRIES - 1; j >= 0; j--) begin
      if (ROM_TAG[j] == tag) hit = 4'(j);
    end
    return hit;
  endfunction

  // Terminal value bytes; anything not listed is zero.
  function automatic logic [7:0] rom_byte(input logic [3:0] entry, input int idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < ROM_STORED) begin
      case (entry)
        4'd0: begin
          if (idx == 0) b = 8'hC8;
          if (idx == 1) b = 8'h80;
        end
        4'd2: begin
          if (idx == 0) b = 8'h01;
        end
        4'd3: begin
          if (idx == 0) b = 8'h79;
          if (idx == 2) b = 8'h40;
          if (idx == 3) b = 8'h80;
        end
        4'd4: begin
          if (idx == 3) b = 8'h10;
        end
        4'd6, 4'd7: begin
          if (idx == 0) b = 8'h01;
          if (idx == 1) b = 8'h24;
        end
        4'd9: begin
          if (idx == 0) b = 8'h19;
          if (idx == 1) b = 8'h01;
          if (idx == 2) b = 8'h01;
        end
        4'd12: begin
          if (idx == 0) b = 8'h82;
          if (idx == 1) b = 8'h3D;
          if (idx == 2) b = 8'hDE;
          if (idx == 3) b = 8'h7A;
        end
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // One table row: bpr bytes of an entry, earliest byte in the top used byte.
  function automatic logic [63:0] rom_row(input logic [3:0] entry, input int chunk,
                                          input int bpr, input int entry_bytes);
    logic [63:0] row;
    int          idx;
    row = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < bpr) begin
        idx = chunk * bpr + i;
        row = {row[55:0], (idx < entry_bytes) ? rom_byte(entry, idx) : 8'h00};
      end
    end
    return row;
  endfunction

endpackage

// File: hw/rtl/dvf_ram.sv
module dvf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 39,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dol_default_value_filler.sv
// Channel   | Dir | tdata                                  | tuser          | tlast
// s_axis    | in  | [7:0] list_byte                        | first_of_list  | -
// m_axis    | out | [63:0] fill_bytes, [67:64] byte_count  | tag_known      | last_of_run
//
// Tag bytes are taken one word per cycle while no table load or run is active.
// A nonzero length byte starts a run: one result word per cycle while the
// queue has room, input held off until the last read of the run has issued.
// Each result is one read of the value table RAM; that port sets the rate.
// After rst the table is loaded one row per cycle, ROM_ENTRIES * ceil(
// ENTRY_BYTES / BYTES_PER_RESULT) rows (39 at defaults), input held off.
// Output stalls back up into a 2-word queue; reads only issue with room.
`include "dol_default_value_filler_macros.svh"

module dol_default_value_filler #(
  parameter int ENTRY_BYTES      = dvf_pkg::ENTRY_BYTES,
  parameter int BYTES_PER_RESULT = dvf_pkg::BYTES_PER_RESULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] list_byte
  input  logic        s_axis_tuser,   // [0] first_of_list
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] fill_bytes, [67:64] byte_count, rest 0
  output logic        m_axis_tuser,   // [0] tag_known
  output logic        m_axis_tlast
);

  localparam int BPR    = BYTES_PER_RESULT;
  localparam int W      = BPR * 8;
  localparam int CHUNKS = (ENTRY_BYTES + BPR - 1) / BPR;
  localparam int ROWS   = dvf_pkg::ROM_ENTRIES * CHUNKS;
  localparam int AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CKW    = $clog2(CHUNKS + 1);
  localparam int KW     = $clog2(dvf_pkg::MAX_RESULTS);
  localparam int CMPW   = (KW > CKW) ? KW + 1 : CKW + 1;

  typedef enum logic [1:0] {PH_TAG0, PH_TAG1, PH_LEN} phase_t;

  // ---------------- table load after reset ----------------
  logic           init_busy;
  logic [3:0]     ld_entry;
  logic [CKW-1:0] ld_chunk;
  logic [AW-1:0]  ld_addr;
  logic [W-1:0]   ld_row;

  assign ld_row = W'(dvf_pkg::rom_row(ld_entry, int'(ld_chunk), BPR, ENTRY_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      init_busy <= 1'b1;
      ld_entry  <= '0;
      ld_chunk  <= '0;
      ld_addr   <= '0;
    end else if (init_busy) begin
      ld_addr <= ld_addr + AW'(1);
      if (ld_chunk == CKW'(CHUNKS - 1)) begin
        ld_chunk <= '0;
        ld_entry <= ld_entry + 4'd1;
        if (ld_entry == 4'(dvf_pkg::ROM_ENTRIES - 1)) init_busy <= 1'b0;
      end else begin
        ld_chunk <= ld_chunk + CKW'(1);
      end
    end
  end

  // ---------------- parse ----------------
  phase_t      phase;
  logic [7:0]  held_tag;
  logic [3:0]  entry;
  logic        run_active;
  logic        in_acc;
  logic [7:0]  b;
  logic        first;

  // run state
  logic [7:0]     rem;
  logic [KW-1:0]  k;
  logic [AW-1:0]  base;
  logic           run_known;

  assign s_axis_tready = !init_busy && !run_active;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign b      = s_axis_tdata;
  assign first  = s_axis_tuser;

  // issue side
  logic        issue;
  logic [3:0]  iss_cnt;
  logic        iss_last;
  logic        iss_zero;
  logic [AW-1:0] raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG0;
      held_tag   <= '0;
      entry      <= '0;
      run_active <= 1'b0;
    end else begin
      if (in_acc) begin
        case (first ? PH_TAG0 : phase)
          PH_TAG1: begin
            entry <= dvf_pkg::match_tag({held_tag, b});
            phase <= PH_LEN;
          end
          PH_LEN: begin
            phase <= PH_TAG0;
            if (b != 8'd0) begin
              run_active <= 1'b1;
              rem        <= b;
              k          <= '0;
              run_known  <= (entry < dvf_pkg::UNKNOWN_ENTRY);
              base       <= (entry < dvf_pkg::UNKNOWN_ENTRY) ?
                            AW'(int'(entry) * CHUNKS) : '0;
            end
          end
          default: begin
            // expecting a first tag byte (also the unused phase code)
            if (dvf_pkg::is_short_tag(b)) begin
              entry <= dvf_pkg::match_tag({8'h00, b});
              phase <= PH_LEN;
            end else begin
              held_tag <= b;
              phase    <= PH_TAG1;
            end
          end
        endcase
      end
      if (issue) begin
        rem <= rem - 8'(iss_cnt);
        k   <= k + KW'(1);
        if (iss_last) run_active <= 1'b0;
      end
    end
  end

  assign iss_cnt  = (rem < 8'(BPR)) ? rem[3:0] : 4'(BPR);
  assign iss_last = (rem <= 8'(BPR)) || (k == KW'(dvf_pkg::MAX_RESULTS - 1));
  assign iss_zero = !run_known || (CMPW'(k) >= CMPW'(CHUNKS));
  assign raddr    = iss_zero ? '0 : base + AW'(k);

  // ---------------- table RAM ----------------
  logic [W-1:0]  rdata;
  logic [AW-1:0] ram_raddr;

  assign ram_raddr = raddr;

  dvf_ram #(.WIDTH(W), .DEPTH(ROWS)) u_ram (
    .clk   (clk),
    .we    (init_busy),
    .waddr (ld_addr),
    .wdata (ld_row),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // read stage: metadata alongside the RAM read
  logic       rd_valid;
  logic [3:0] rd_cnt;
  logic       rd_known;
  logic       rd_last;
  logic       rd_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_cnt   <= iss_cnt;
      rd_known <= run_known;
      rd_last  <= iss_last;
      rd_zero  <= iss_zero;
    end
  end

  // right-align the row to the valid byte count
  logic [3:0]        sh_bytes;
  logic [5:0]        sh_bits;
  dvf_pkg::out_word_t push_word;

  assign sh_bytes = 4'(BPR) - rd_cnt;
  assign sh_bits  = {sh_bytes[2:0], 3'b000};
  assign push_word.fill  = rd_zero ? 64'd0 : (64'(rdata) >> sh_bits);
  assign push_word.count = rd_cnt;
  assign push_word.known = rd_known;
  assign push_word.last  = rd_last;

  // ---------------- output queue, 2 words ----------------
  dvf_pkg::out_word_t q_mem [2];
  logic       q_head;
  logic       q_tail;
  logic [1:0] q_cnt;
  logic       pop;
  logic [1:0] pend;

  assign pop  = m_axis_tvalid && m_axis_tready;
  assign pend = q_cnt + 2'(rd_valid) - 2'(pop);
  assign issue = run_active && (pend < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head <= 1'b0;
      q_tail <= 1'b0;
      q_cnt  <= '0;
    end else begin
      if (rd_valid) q_tail <= ~q_tail;
      if (pop) q_head <= ~q_head;
      q_cnt <= q_cnt + 2'(rd_valid) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) q_mem[q_tail] <= push_word;
  end

  dvf_pkg::out_word_t head_word;
  assign head_word     = q_mem[q_head];
  assign m_axis_tvalid = (q_cnt != 2'd0);
  assign m_axis_tdata  = {4'd0, head_word.count, head_word.fill};
  assign m_axis_tuser  = head_word.known;
  assign m_axis_tlast  = head_word.last;

  // ---------------- checks ----------------
  `DVF_ASSERT_NOW(a_q_no_overflow, clk, rst, rd_valid && (q_cnt == 2'd2), pop, "queue overflow")
  `DVF_ASSERT_NOW(a_count_range, clk, rst, m_axis_tvalid, (m_axis_tdata[67:64] != 4'd0) && (m_axis_tdata[67:64] <= 4'(BPR)), "byte count out of range")
  `DVF_ASSERT_NOW(a_unknown_zero, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[63:0] == 64'd0, "unknown tag with nonzero fill")
  `DVF_ASSERT_NEXT(a_run_ends_last, clk, rst, issue && iss_last, !run_active, "run kept going after its last word")

endmodule

// File: test/dol_default_value_filler_tb.sv
module dol_default_value_filler_tb;

  localparam int RANDOM_ITEMS = 340;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PREFIX_BYTES = 6;   // terminal values hold nothing past byte 5

  // Terminal tags, two-byte form; one-byte tags sit in the low byte.
  localparam logic [15:0] TAG_TXN_INFO      = 16'h9F59;
  localparam logic [15:0] TAG_TXN_KIND      = 16'h9F5A;
  localparam logic [15:0] TAG_MERCHANT      = 16'h9F58;
  localparam logic [15:0] TAG_TTQ           = 16'h9F66;
  localparam logic [15:0] TAG_AMOUNT        = 16'h9F02;
  localparam logic [15:0] TAG_AMOUNT_OTHER  = 16'h9F03;
  localparam logic [15:0] TAG_COUNTRY       = 16'h9F1A;
  localparam logic [15:0] TAG_CURRENCY      = 16'h5F2A;
  localparam logic [15:0] TAG_TVR           = 16'h0095;
  localparam logic [15:0] TAG_DATE          = 16'h009A;
  localparam logic [15:0] TAG_TXN_TYPE      = 16'h009C;
  localparam logic [15:0] TAG_TC_HASH       = 16'h0098;
  localparam logic [15:0] TAG_UNPREDICTABLE = 16'h9F37;
  localparam logic [15:0] TAG_UNLISTED      = 16'hFFFF;

  localparam logic [15:0] TERM_TAGS [dvf_pkg::ROM_ENTRIES] = '{
    TAG_TXN_INFO, TAG_TXN_KIND, TAG_MERCHANT, TAG_TTQ, TAG_AMOUNT, TAG_AMOUNT_OTHER,
    TAG_COUNTRY, TAG_CURRENCY, TAG_TVR, TAG_DATE, TAG_TXN_TYPE, TAG_TC_HASH,
    TAG_UNPREDICTABLE
  };

  // Leading bytes of each terminal value, earliest byte at the top.
  localparam logic [47:0] TERM_VALUES [dvf_pkg::ROM_ENTRIES] = '{
    48'hC880_0000_0000, 48'h0000_0000_0000, 48'h0100_0000_0000,
    48'h7900_4080_0000, 48'h0000_0010_0000, 48'h0000_0000_0000,
    48'h0124_0000_0000, 48'h0124_0000_0000, 48'h0000_0000_0000,
    48'h1901_0100_0000, 48'h0000_0000_0000, 48'h0000_0000_0000,
    48'h823D_DE7A_0000
  };

  typedef enum logic [1:0] {
    PH_TAG_HIGH = 2'd0,
    PH_TAG_LOW  = 2'd1,
    PH_LENGTH   = 2'd2,
    PH_SPARE    = 2'd3
  } parse_phase_t;

  typedef struct packed {
    logic [63:0] fill;
    logic [3:0]  count;
    logic        known;
    logic        last;
  } fill_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [71:0] m_axis_tdata;
  wire         m_axis_tuser;
  wire         m_axis_tlast;

  // Predictor state.
  parse_phase_t list_phase;
  logic [7:0]   tag_high;
  logic [3:0]   value_entry;
  fill_word_t   expected_fill [$];

  int  mismatches  = 0;
  int  words_sent  = 0;
  int  cycle_count = 0;
  int  hold_req    = 0;
  bit  tx_idle_on  = 1'b1;
  bit  rx_idle_on  = 1'b1;

  always #1 clk = ~clk;

  dol_default_value_filler DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic one_byte_tag(input logic [7:0] b);
    return b == TAG_TVR[7:0] || b == TAG_DATE[7:0] ||
           b == TAG_TXN_TYPE[7:0] || b == TAG_TC_HASH[7:0];
  endfunction

  function automatic logic [3:0] entry_of_tag(input logic [15:0] tag);
    logic [3:0] hit;
    hit = dvf_pkg::UNKNOWN_ENTRY;
    for (int j = dvf_pkg::ROM_ENTRIES - 1; j >= 0; j--) begin
      if (TERM_TAGS[j] == tag) hit = 4'(j);
    end
    return hit;
  endfunction

  // Entry codes 13..15 and anything past the stored bytes give zero.
  function automatic logic [7:0] term_value_byte(input logic [3:0] entry, input int k);
    if (entry >= dvf_pkg::ROM_ENTRIES || k >= dvf_pkg::ROM_STORED ||
        k >= dvf_pkg::ENTRY_BYTES || k >= PREFIX_BYTES) begin
      return 8'h00;
    end
    return TERM_VALUES[entry][47 - 8 * k -: 8];
  endfunction

  function automatic logic [7:0] pick_one_byte_tag();
    case ($urandom_range(3))
      0:       return TAG_TVR[7:0];
      1:       return TAG_DATE[7:0];
      2:       return TAG_TXN_TYPE[7:0];
      default: return TAG_TC_HASH[7:0];
    endcase
  endfunction

  // Advances the parse by one list byte and queues the words a length byte causes.
  task automatic predict_fill(input logic [7:0] b, input logic is_first);
    fill_word_t w;
    int         len;
    int         pos;
    int         cnt;
    int         n;
    if (is_first) list_phase = PH_TAG_HIGH;
    case (list_phase)
      PH_TAG_LOW: begin
        value_entry = entry_of_tag({tag_high, b});
        list_phase  = PH_LENGTH;
      end
      PH_LENGTH: begin
        list_phase = PH_TAG_HIGH;
        len = b;
        pos = 0;
        n   = 0;
        while (pos < len && n < dvf_pkg::MAX_RESULTS) begin
          cnt = (len - pos < dvf_pkg::BYTES_PER_RESULT) ? len - pos
                                                        : dvf_pkg::BYTES_PER_RESULT;
          w.fill = '0;
          for (int i = 0; i < cnt; i++) begin
            w.fill = {w.fill[55:0], term_value_byte(value_entry, pos + i)};
          end
          pos += cnt;
          w.count = 4'(cnt);
          w.known = value_entry < dvf_pkg::UNKNOWN_ENTRY;
          w.last  = pos >= len || n == dvf_pkg::MAX_RESULTS - 1;
          expected_fill.push_back(w);
          n++;
        end
      end
      default: begin
        // phase 3 never arises but behaves as tag start
        if (one_byte_tag(b)) begin
          value_entry = entry_of_tag({8'h00, b});
          list_phase  = PH_LENGTH;
        end else begin
          tag_high   = b;
          list_phase = PH_TAG_LOW;
        end
      end
    endcase
  endtask

  // Offers one list byte, random gaps first, and returns at its handshake edge.
  task automatic send_word(input logic [7:0] b, input logic is_first);
    while (tx_idle_on && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= is_first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_fill(b, is_first);
    words_sent++;
  endtask

  task automatic send_tag(input logic [15:0] tag, input logic is_first);
    if (tag[15:8] == 8'h00 && one_byte_tag(tag[7:0])) begin
      send_word(tag[7:0], is_first);
    end else begin
      send_word(tag[15:8], is_first);
      send_word(tag[7:0], 1'b0);
    end
  endtask

  task automatic send_item(input logic [15:0] tag, input logic [7:0] len,
                           input logic is_first);
    send_tag(tag, is_first);
    send_word(len, 1'b0);
  endtask

  // Drops valid and waits for every queued word to come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_fill.size() != 0) @(posedge clk);
  endtask

  task automatic test_one_byte_tags();
    send_item(TAG_TVR, 8'd5, 1'b1);
    send_item(TAG_DATE, 8'd3, 1'b0);
    send_item(TAG_TXN_TYPE, 8'd1, 1'b0);
    send_item(TAG_TC_HASH, 8'd0, 1'b0);   // zero length: no words
  endtask

  task automatic test_two_byte_tags();
    send_item(TAG_UNPREDICTABLE, 8'd4, 1'b0);
    // 0x00 high byte in front of a one-byte tag still matches it
    send_word(8'h00, 1'b0);
    send_word(TAG_TVR[7:0], 1'b0);
    send_word(8'd2, 1'b0);
    send_item(TAG_UNLISTED, 8'd9, 1'b0);  // unknown: zero fill
  endtask

  task automatic test_long_runs();
    send_item(TAG_TTQ, 8'd255, 1'b0);
    send_item(TAG_COUNTRY, 8'd24, 1'b0);  // runs past the stored value bytes
  endtask

  task automatic test_cut_off_lists();
    send_word(TAG_UNPREDICTABLE[15:8], 1'b1);
    send_word(TAG_UNPREDICTABLE[7:0], 1'b0);
    send_item(TAG_DATE, 8'd2, 1'b1);       // restart where a length was due
    send_word(TAG_TVR[7:0], 1'b0);
    send_item(TAG_CURRENCY, 8'd3, 1'b1);
  endtask

  // Output held off long enough that the block backs up and stalls its input.
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int r = 0; r < 3; r++) begin
      send_item(TAG_UNPREDICTABLE, 8'd40, 1'b0);
    end
    send_item(TAG_TVR, 8'd16, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_lists();
    int         start;
    int         n;
    int         pick;
    logic       is_first;
    logic       restart;
    logic [7:0] hi;
    start   = words_sent;
    restart = 1'b1;
    while (words_sent - start < RANDOM_ITEMS) begin
      n = words_sent - start;
      tx_idle_on = !(n >= 120 && n < 220);
      rx_idle_on <= !(n >= 120 && n < 220);
      is_first = restart || $urandom_range(3) == 0;
      restart  = 1'b0;
      pick = $urandom_range(99);
      if (pick < 10) begin
        // noise byte, any value and any first mark
        send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
        continue;
      end
      if (pick < 60) begin
        send_tag(TERM_TAGS[$urandom_range(dvf_pkg::ROM_ENTRIES - 1)], is_first);
      end else if (pick < 70) begin
        send_word(8'h00, is_first);
        send_word(pick_one_byte_tag(), 1'b0);
      end else begin
        hi = 8'($urandom_range(255));
        send_word(hi, is_first);
        if (!one_byte_tag(hi)) send_word(8'($urandom_range(255)), 1'b0);
      end
      if ($urandom_range(99) < 8) begin
        restart = 1'b1;   // list ends mid-item
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      send_word(8'($urandom_range(12)), 1'b0);
        else if (pick < 92) send_word(8'($urandom_range(40, 13)), 1'b0);
        else                send_word(8'($urandom_range(255, 41)), 1'b0);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  initial begin : drive_ready
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
      end
      m_axis_tready <= !rx_idle_on || $urandom_range(99) >= 19;
    end
  end

  // Compares each accepted word with the oldest expected one.
  always @(posedge clk) begin : check_results
    fill_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_fill.size() == 0) begin
        $error("unexpected word: tdata=%h tuser=%b tlast=%b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_fill.pop_front();
        if (m_axis_tdata[63:0] !== want.fill) begin
          $error("fill_bytes: expected %h, got %h", want.fill, m_axis_tdata[63:0]);
          mismatches++;
        end
        if (m_axis_tdata[67:64] !== want.count) begin
          $error("byte_count: expected %0d, got %0d", want.count, m_axis_tdata[67:64]);
          mismatches++;
        end
        if (m_axis_tdata[71:68] !== 4'h0) begin
          $error("tdata pad: expected 0, got %h", m_axis_tdata[71:68]);
          mismatches++;
        end
        if (m_axis_tuser !== want.known) begin
          $error("tag_known: expected %b, got %b", want.known, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    list_phase  = PH_TAG_HIGH;
    tag_high    = 8'h00;
    value_entry = 4'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // table load after reset is covered by waiting on tready
    test_one_byte_tags();
    test_two_byte_tags();
    test_long_runs();
    test_cut_off_lists();
    test_backpressure();
    test_random_lists();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_fill.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/dvf_pkg.sv
hw/rtl/dvf_ram.sv
hw/rtl/dol_default_value_filler.sv
test/dol_default_value_filler_tb.sv
